@@ rtl/rpps_pkg.sv @@
package rpps_pkg;

	// Sequencer phases, as reported on the phase output
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_RELAY   = 2'd1,
		PH_WAIT    = 2'd2,
		PH_CAPTURE = 2'd3
	} phase_t;

	// Configuration register indexes
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam logic [CFG_IDX_BITS-1:0] REG_RELAY_MS      = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PHOTO_INTERVAL = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PHOTO_COUNT   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_PRESS_LOCKOUT = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_SLOW_BLINK    = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_FAST_BLINK    = 3'd5;

	// Register reset values
	localparam logic [15:0] RELAY_MS_RST       = 16'd2000;
	localparam logic [15:0] PHOTO_INTERVAL_RST = 16'd5000;
	localparam logic [7:0]  PHOTO_COUNT_RST    = 8'd4;
	localparam logic [15:0] PRESS_LOCKOUT_RST  = 16'd200;
	localparam logic [15:0] SLOW_BLINK_RST     = 16'd2000;
	localparam logic [15:0] FAST_BLINK_RST     = 16'd100;

	localparam logic [7:0] CAPTURES_MAX = 8'hFF;

	// Configuration seen by the sequencer core
	typedef struct packed {
		logic [15:0] relay_ms;
		logic [15:0] photo_interval_ms;
		logic [7:0]  photo_count;
		logic [15:0] press_lockout_ms;
		logic [15:0] slow_blink_ms;
		logic [15:0] fast_blink_ms;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic        relay_on;
		logic        capture_pulse;
		logic [7:0]  capture_number;
		logic        report_on;
		logic        report_off;
		logic        trigger_ignored;
		logic        sequence_done;
		logic        status_led_lit;
		phase_t      phase;
	} res_t;

endpackage

@@ rtl/rpps_cfg.sv @@
module rpps_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [rpps_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [rpps_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	output rpps_pkg::cfg_t                        cfg
);

	rpps_pkg::cfg_t cfg_q;

	// Register file, written without wait
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.relay_ms          <= rpps_pkg::RELAY_MS_RST;
			cfg_q.photo_interval_ms <= rpps_pkg::PHOTO_INTERVAL_RST;
			cfg_q.photo_count       <= rpps_pkg::PHOTO_COUNT_RST;
			cfg_q.press_lockout_ms  <= rpps_pkg::PRESS_LOCKOUT_RST;
			cfg_q.slow_blink_ms     <= rpps_pkg::SLOW_BLINK_RST;
			cfg_q.fast_blink_ms     <= rpps_pkg::FAST_BLINK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rpps_pkg::REG_RELAY_MS:       cfg_q.relay_ms          <= cfg_data;
				rpps_pkg::REG_PHOTO_INTERVAL: cfg_q.photo_interval_ms <= cfg_data;
				rpps_pkg::REG_PHOTO_COUNT:    cfg_q.photo_count       <= cfg_data[7:0];
				rpps_pkg::REG_PRESS_LOCKOUT:  cfg_q.press_lockout_ms  <= cfg_data;
				rpps_pkg::REG_SLOW_BLINK:     cfg_q.slow_blink_ms     <= cfg_data;
				rpps_pkg::REG_FAST_BLINK:     cfg_q.fast_blink_ms     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/rpps_core.sv @@
module rpps_core #(
	parameter int TIMER_BITS = 16
) (
	input  rpps_pkg::cfg_t          cfg,
	input  logic                    button_level,
	input  logic                    remote_trigger,
	input  logic                    link_up,
	input  rpps_pkg::phase_t        phase_cur,
	input  logic [TIMER_BITS-1:0]   elapsed_cur,
	input  logic [7:0]              captures_cur,
	input  logic                    prev_button_cur,
	input  logic [TIMER_BITS-1:0]   since_press_cur,
	input  logic [TIMER_BITS-1:0]   since_toggle_cur,
	input  logic                    led_cur,
	output rpps_pkg::phase_t        phase_nxt,
	output logic [TIMER_BITS-1:0]   elapsed_nxt,
	output logic [7:0]              captures_nxt,
	output logic                    prev_button_nxt,
	output logic [TIMER_BITS-1:0]   since_press_nxt,
	output logic [TIMER_BITS-1:0]   since_toggle_nxt,
	output logic                    led_nxt,
	output rpps_pkg::res_t          res
);

	localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
	localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

	// Limit clipped to the timer range
	function automatic logic [TIMER_BITS-1:0] clip(input logic [15:0] v);
		logic [CW-1:0] v_w;
		logic [CW-1:0] m_w;
		v_w = CW'(v);
		m_w = CW'(TMAX);
		return (v_w > m_w) ? TIMER_BITS'(m_w) : TIMER_BITS'(v_w);
	endfunction

	function automatic logic [TIMER_BITS-1:0] tinc(input logic [TIMER_BITS-1:0] t);
		return (t == TMAX) ? t : t + TIMER_BITS'(1);
	endfunction

	logic [TIMER_BITS-1:0] el_inc, sp_inc, st_inc, period;
	logic                  r_fire, b_trig, b_fire;
	rpps_pkg::phase_t      ph1, ph2;
	logic [TIMER_BITS-1:0] el2;
	logic [7:0]            cd2, cd_inc;

	// Timers first, then the LED
	always_comb begin
		el_inc = tinc(elapsed_cur);
		sp_inc = tinc(since_press_cur);
		st_inc = tinc(since_toggle_cur);
		period = clip(link_up ? cfg.slow_blink_ms : cfg.fast_blink_ms);
		if (st_inc >= period) begin
			since_toggle_nxt = '0;
			led_nxt = ~led_cur;
		end else begin
			since_toggle_nxt = st_inc;
			led_nxt = led_cur;
		end
	end

	// Triggers: remote strobe before button edge
	always_comb begin
		r_fire = link_up && remote_trigger && (phase_cur == rpps_pkg::PH_IDLE);
		ph1 = r_fire ? rpps_pkg::PH_RELAY : phase_cur;
		b_trig = link_up && !button_level && prev_button_cur &&
			(sp_inc > clip(cfg.press_lockout_ms));
		b_fire = b_trig && (ph1 == rpps_pkg::PH_IDLE);
		ph2 = b_fire ? rpps_pkg::PH_RELAY : ph1;
		el2 = (r_fire || b_fire) ? '0 : el_inc;
		cd2 = (r_fire || b_fire) ? 8'd0 : captures_cur;
		since_press_nxt = b_trig ? '0 : sp_inc;
		prev_button_nxt = link_up ? button_level : prev_button_cur;
	end

	// One sequencer step, frozen while the link is down
	always_comb begin
		phase_nxt = ph2;
		elapsed_nxt = el2;
		captures_nxt = cd2;
		cd_inc = (cd2 < rpps_pkg::CAPTURES_MAX) ? cd2 + 8'd1 : cd2;
		res = '0;
		res.report_on = r_fire || b_fire;
		res.trigger_ignored = (link_up && remote_trigger && !r_fire) || (b_trig && !b_fire);
		if (link_up) begin
			case (ph2)
				rpps_pkg::PH_RELAY: begin
					if (el2 >= clip(cfg.relay_ms)) begin
						res.report_off = 1'b1;
						phase_nxt = rpps_pkg::PH_WAIT;
						elapsed_nxt = clip(cfg.photo_interval_ms);
						captures_nxt = 8'd0;
					end
				end
				rpps_pkg::PH_WAIT: begin
					if (el2 >= clip(cfg.photo_interval_ms)) begin
						phase_nxt = rpps_pkg::PH_CAPTURE;
						elapsed_nxt = '0;
					end
				end
				rpps_pkg::PH_CAPTURE: begin
					res.capture_pulse = 1'b1;
					res.capture_number = cd2;
					captures_nxt = cd_inc;
					if (cd_inc >= cfg.photo_count) begin
						phase_nxt = rpps_pkg::PH_IDLE;
						res.sequence_done = 1'b1;
					end else begin
						phase_nxt = rpps_pkg::PH_WAIT;
						elapsed_nxt = '0;
					end
				end
				default: ;
			endcase
		end
		res.relay_on = (phase_nxt == rpps_pkg::PH_RELAY);
		res.phase = phase_nxt;
		res.status_led_lit = led_nxt;
	end

endmodule

@@ rtl/relay_pulse_photo_sequencer.sv @@
// Relay pulse and photo capture sequencer, one tick per transaction.
// Results go from the input register through the one-step state update to the result register.
// Throughput: 1 tick per cycle unless out_ready stalls the result register; that update sets it.
// Reset (arst_n low, asynchronous): idle phase, timers zero, button released, LED unlit,
// configuration at its reset values, both pipeline stages empty.
module relay_pulse_photo_sequencer #(
	parameter int TIMER_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rpps_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [rpps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                button_level,
	input  logic                                remote_trigger,
	input  logic                                link_up,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                relay_on,
	output logic                                capture_pulse,
	output logic [7:0]                          capture_number,
	output logic                                report_on,
	output logic                                report_off,
	output logic                                trigger_ignored,
	output logic                                sequence_done,
	output logic                                status_led_lit,
	output logic [1:0]                          phase
);

	rpps_pkg::cfg_t cfg;

	logic valid_s1, btn_s1, rem_s1, link_s1;
	logic valid_s2;
	rpps_pkg::res_t res_s2;

	rpps_pkg::phase_t      phase_q, phase_d;
	logic [TIMER_BITS-1:0] elapsed_q, elapsed_d;
	logic [7:0]            captures_q, captures_d;
	logic                  prev_button_q, prev_button_d;
	logic [TIMER_BITS-1:0] since_press_q, since_press_d;
	logic [TIMER_BITS-1:0] since_toggle_q, since_toggle_d;
	logic                  led_q, led_d;
	rpps_pkg::res_t        res_d;

	logic advance;

	rpps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rpps_core #(.TIMER_BITS(TIMER_BITS)) u_core (
		.cfg              (cfg),
		.button_level     (btn_s1),
		.remote_trigger   (rem_s1),
		.link_up          (link_s1),
		.phase_cur        (phase_q),
		.elapsed_cur      (elapsed_q),
		.captures_cur     (captures_q),
		.prev_button_cur  (prev_button_q),
		.since_press_cur  (since_press_q),
		.since_toggle_cur (since_toggle_q),
		.led_cur          (led_q),
		.phase_nxt        (phase_d),
		.elapsed_nxt      (elapsed_d),
		.captures_nxt     (captures_d),
		.prev_button_nxt  (prev_button_d),
		.since_press_nxt  (since_press_d),
		.since_toggle_nxt (since_toggle_d),
		.led_nxt          (led_d),
		.res              (res_d)
	);

	// Stage 1 moves on when the result register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			btn_s1  <= button_level;
			rem_s1  <= remote_trigger;
			link_s1 <= link_up;
		end
	end

	// Sequencer state, updated once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= rpps_pkg::PH_IDLE;
			elapsed_q      <= '0;
			captures_q     <= 8'd0;
			prev_button_q  <= 1'b1;
			since_press_q  <= '0;
			since_toggle_q <= '0;
			led_q          <= 1'b0;
		end else if (advance) begin
			phase_q        <= phase_d;
			elapsed_q      <= elapsed_d;
			captures_q     <= captures_d;
			prev_button_q  <= prev_button_d;
			since_press_q  <= since_press_d;
			since_toggle_q <= since_toggle_d;
			led_q          <= led_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid       = valid_s2;
	assign relay_on        = res_s2.relay_on;
	assign capture_pulse   = res_s2.capture_pulse;
	assign capture_number  = res_s2.capture_number;
	assign report_on       = res_s2.report_on;
	assign report_off      = res_s2.report_off;
	assign trigger_ignored = res_s2.trigger_ignored;
	assign sequence_done   = res_s2.sequence_done;
	assign status_led_lit  = res_s2.status_led_lit;
	assign phase           = res_s2.phase;

endmodule

@@ rtl/rpps_checker.sv @@
module rpps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       relay_on,
	input logic       capture_pulse,
	input logic [7:0] capture_number,
	input logic       report_off,
	input logic       sequence_done,
	input logic [1:0] phase
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(capture_number) &&
		$stable(phase) && $stable(capture_pulse))
		else $error("result changed while stalled");

	// Relay drive follows the relay phase
	a_relay_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (relay_on == (phase == rpps_pkg::PH_RELAY)))
		else $error("relay_on disagrees with phase");

	// No capture, no capture index
	a_cap_number: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !capture_pulse |-> capture_number == 8'd0)
		else $error("capture_number set without pulse");

	// Sequence end comes with the last pulse and returns to idle
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sequence_done |-> capture_pulse && phase == rpps_pkg::PH_IDLE)
		else $error("sequence_done without final capture");

	// Relay release always enters the wait phase
	a_off_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && report_off |-> phase == rpps_pkg::PH_WAIT && !relay_on)
		else $error("report_off outside wait phase");

endmodule

bind relay_pulse_photo_sequencer rpps_checker u_rpps_checker (.*);

@@ sim/relay_pulse_photo_sequencer_tb.sv @@
module relay_pulse_photo_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_we;
	logic [rpps_pkg::CFG_IDX_BITS-1:0]  cfg_index;
	logic [rpps_pkg::CFG_DATA_BITS-1:0] cfg_data;
	logic                               in_valid;
	logic                               in_ready;
	logic                               button_level;
	logic                               remote_trigger;
	logic                               link_up;
	logic                               out_valid;
	logic                               out_ready;
	logic                               relay_on;
	logic                               capture_pulse;
	logic [7:0]                         capture_number;
	logic                               report_on;
	logic                               report_off;
	logic                               trigger_ignored;
	logic                               sequence_done;
	logic                               status_led_lit;
	logic [1:0]                         phase;

	relay_pulse_photo_sequencer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.button_level   (button_level),
		.remote_trigger (remote_trigger),
		.link_up        (link_up),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.relay_on       (relay_on),
		.capture_pulse  (capture_pulse),
		.capture_number (capture_number),
		.report_on      (report_on),
		.report_off     (report_off),
		.trigger_ignored(trigger_ignored),
		.sequence_done  (sequence_done),
		.status_led_lit (status_led_lit),
		.phase          (phase)
	);

	// Shadow copy of the sequencer state and its registers
	rpps_pkg::cfg_t   cfg;
	rpps_pkg::phase_t seq_ph;
	logic [15:0]      ph_ticks;
	logic [15:0]      press_age;
	logic [15:0]      blink_age;
	logic [7:0]       shots;
	logic             btn_prev;
	logic             led;

	rpps_pkg::res_t tick_results_q[$];
	int   fail_count = 0;
	bit   gaps_on = 1'b1;

	// 12 ns clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the handshakes hang
	initial begin
		#1ms;
		$display("tb: failure");
		$finish;
	end

	// Timers stop at all ones rather than wrapping
	function automatic logic [15:0] sat_inc(input logic [15:0] t);
		return (t == 16'hFFFF) ? t : t + 16'd1;
	endfunction

	// A trigger only starts a sequence from idle
	function automatic bit try_start();
		if (seq_ph != rpps_pkg::PH_IDLE)
			return 1'b0;
		seq_ph   = rpps_pkg::PH_RELAY;
		ph_ticks = '0;
		shots    = '0;
		return 1'b1;
	endfunction

	// Advance the shadow state by one tick and queue the result it gives
	task automatic predict_tick(input logic btn, input logic rem, input logic lnk);
		rpps_pkg::res_t r;
		logic [15:0]    period;
		r = '0;
		blink_age = sat_inc(blink_age);
		ph_ticks  = sat_inc(ph_ticks);
		press_age = sat_inc(press_age);

		period = lnk ? cfg.slow_blink_ms : cfg.fast_blink_ms;
		if (blink_age >= period) begin
			blink_age = '0;
			led       = ~led;
		end

		// sequencer and button are frozen while the link is down
		if (lnk) begin
			if (rem) begin
				if (try_start())
					r.report_on = 1'b1;
				else
					r.trigger_ignored = 1'b1;
			end
			if (!btn && btn_prev && press_age > cfg.press_lockout_ms) begin
				press_age = '0;
				if (try_start())
					r.report_on = 1'b1;
				else
					r.trigger_ignored = 1'b1;
			end
			btn_prev = btn;

			case (seq_ph)
				rpps_pkg::PH_RELAY: if (ph_ticks >= cfg.relay_ms) begin
					r.report_off = 1'b1;
					seq_ph       = rpps_pkg::PH_WAIT;
					ph_ticks     = cfg.photo_interval_ms;
					shots        = '0;
				end
				rpps_pkg::PH_WAIT: if (ph_ticks >= cfg.photo_interval_ms) begin
					seq_ph   = rpps_pkg::PH_CAPTURE;
					ph_ticks = '0;
				end
				rpps_pkg::PH_CAPTURE: begin
					r.capture_pulse  = 1'b1;
					r.capture_number = shots;
					if (shots != rpps_pkg::CAPTURES_MAX)
						shots++;
					if (shots >= cfg.photo_count) begin
						seq_ph          = rpps_pkg::PH_IDLE;
						r.sequence_done = 1'b1;
					end else begin
						seq_ph   = rpps_pkg::PH_WAIT;
						ph_ticks = '0;
					end
				end
				default: ;
			endcase
		end

		r.relay_on       = (seq_ph == rpps_pkg::PH_RELAY);
		r.status_led_lit = led;
		r.phase          = seq_ph;
		tick_results_q.push_back(r);
	endtask

	function automatic void compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Result checker: each accepted transaction against the oldest prediction
	always @(posedge clk) begin : result_check
		rpps_pkg::res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (tick_results_q.size() == 0) begin
				$error("result transaction with no tick outstanding");
				fail_count++;
			end else begin
				want = tick_results_q.pop_front();
				compare_field("relay_on", 8'(want.relay_on), 8'(relay_on));
				compare_field("capture_pulse", 8'(want.capture_pulse), 8'(capture_pulse));
				compare_field("capture_number", want.capture_number, capture_number);
				compare_field("report_on", 8'(want.report_on), 8'(report_on));
				compare_field("report_off", 8'(want.report_off), 8'(report_off));
				compare_field("trigger_ignored", 8'(want.trigger_ignored),
					8'(trigger_ignored));
				compare_field("sequence_done", 8'(want.sequence_done), 8'(sequence_done));
				compare_field("status_led_lit", 8'(want.status_led_lit),
					8'(status_led_lit));
				compare_field("phase", 8'(want.phase), 8'(phase));
			end
		end
	end

	// Result side back-pressure in random bursts
	initial begin : sink_pacing
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (gaps_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// One tick transaction; returns at the edge that accepts it
	task automatic send_tick(input logic btn, input logic rem, input logic lnk);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid       <= 1'b1;
		button_level   <= btn;
		remote_trigger <= rem;
		link_up        <= lnk;
		do @(posedge clk); while (!in_ready);
		predict_tick(btn, rem, lnk);
	endtask

	// Stop sending and wait for every outstanding result
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tick_results_q.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [rpps_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			rpps_pkg::REG_RELAY_MS:       cfg.relay_ms = val;
			rpps_pkg::REG_PHOTO_INTERVAL: cfg.photo_interval_ms = val;
			rpps_pkg::REG_PHOTO_COUNT:    cfg.photo_count = val[7:0];
			rpps_pkg::REG_PRESS_LOCKOUT:  cfg.press_lockout_ms = val;
			rpps_pkg::REG_SLOW_BLINK:     cfg.slow_blink_ms = val;
			rpps_pkg::REG_FAST_BLINK:     cfg.fast_blink_ms = val;
			default: ;
		endcase
	endtask

	task automatic load_config(input logic [15:0] relay, input logic [15:0] interval,
			input logic [15:0] count, input logic [15:0] lockout,
			input logic [15:0] slow, input logic [15:0] fast);
		write_reg(rpps_pkg::REG_RELAY_MS, relay);
		write_reg(rpps_pkg::REG_PHOTO_INTERVAL, interval);
		write_reg(rpps_pkg::REG_PHOTO_COUNT, count);
		write_reg(rpps_pkg::REG_PRESS_LOCKOUT, lockout);
		write_reg(rpps_pkg::REG_SLOW_BLINK, slow);
		write_reg(rpps_pkg::REG_FAST_BLINK, fast);
	endtask

	// Quiet ticks with the link up until the sequence has finished
	task automatic run_to_idle();
		while (seq_ph != rpps_pkg::PH_IDLE)
			send_tick(1'b1, 1'b0, 1'b1);
	endtask

	// Reset configuration: start, retrigger while busy, link drop
	task automatic test_startup();
		send_tick(1'b1, 1'b1, 1'b1);
		send_tick(1'b1, 1'b1, 1'b1);
		send_tick(1'b0, 1'b0, 1'b0);
		drain();
		load_config(16'd1, 16'd1, 16'd2, 16'd3, 16'd3, 16'd1);
		run_to_idle();
		drain();
	endtask

	// Trigger priority, lockout and link freeze (lockout of 3)
	task automatic test_trigger_rules();
		repeat (4) send_tick(1'b1, 1'b0, 1'b1);
		// remote and press together: remote starts, press is flagged
		send_tick(1'b0, 1'b1, 1'b1);
		send_tick(1'b1, 1'b0, 1'b1);
		// second press falls inside the lockout
		send_tick(1'b0, 1'b0, 1'b1);
		send_tick(1'b1, 1'b0, 1'b1);
		// press while busy: ignored but restarts the lockout
		send_tick(1'b0, 1'b0, 1'b1);
		send_tick(1'b0, 1'b0, 1'b1);
		run_to_idle();
		// link down: strobes and presses unseen, last button level kept
		send_tick(1'b0, 1'b1, 1'b0);
		send_tick(1'b0, 1'b1, 1'b0);
		send_tick(1'b0, 1'b0, 1'b1);
		run_to_idle();
		drain();
	endtask

	// All registers zero: relay on and off in one tick, single capture, LED every tick
	task automatic test_zero_settings();
		load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_tick(1'b1, 1'b1, 1'b1);
		run_to_idle();
		repeat (3) send_tick(1'b1, 1'b0, 1'b0);
		send_tick(1'b0, 1'b0, 1'b1);
		run_to_idle();
		drain();
	endtask

	// Random traffic: held button levels, rare strobes, link drops; one noisy batch
	task automatic random_ticks(input int n_ticks, input bit noisy);
		logic btn;
		logic lnk;
		logic rem;
		int   i;
		btn = 1'b1;
		lnk = 1'b1;
		for (i = 0; i < n_ticks; i++) begin
			if (noisy) begin
				btn = 1'($urandom);
				lnk = 1'($urandom);
				rem = 1'($urandom);
			end else begin
				if ($urandom_range(0, 5) == 0)
					btn = ~btn;
				if ($urandom_range(0, 24) == 0)
					lnk = ~lnk;
				rem = ($urandom_range(0, 11) == 0);
			end
			send_tick(btn, rem, lnk);
		end
	endtask

	task automatic test_random_sequences();
		int p;
		for (p = 0; p < 4; p++) begin
			load_config(16'($urandom_range(0, 6)), 16'($urandom_range(0, 5)),
				16'($urandom_range(0, 4)), 16'($urandom_range(0, 8)),
				16'($urandom_range(0, 10)), 16'($urandom_range(0, 6)));
			random_ticks((p == 3) ? 90 : 50, p == 3);
			drain();
		end
	endtask

	// Full 255-capture sequence, so the capture index reaches its top values
	task automatic test_capture_limit();
		load_config(16'd1, 16'd1, 16'd255, 16'd0, 16'd7, 16'd2);
		send_tick(1'b1, 1'b1, 1'b1);
		run_to_idle();
		drain();
	endtask

	// Largest limits: relay held on, then a short relay time ends the sequence
	task automatic test_large_limits();
		load_config(16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFE, 16'hFFFF, 16'hFFFF);
		send_tick(1'b1, 1'b1, 1'b1);
		repeat (20) send_tick(1'b1, 1'b0, 1'b1);
		// press well inside the largest lockout: not a trigger
		send_tick(1'b0, 1'b0, 1'b1);
		drain();
		write_reg(rpps_pkg::REG_RELAY_MS, 16'd1);
		write_reg(rpps_pkg::REG_PHOTO_INTERVAL, 16'd2);
		run_to_idle();
		drain();
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		in_valid       = 1'b0;
		button_level   = 1'b1;
		remote_trigger = 1'b0;
		link_up        = 1'b0;

		// shadow state at its reset values
		cfg.relay_ms          = rpps_pkg::RELAY_MS_RST;
		cfg.photo_interval_ms = rpps_pkg::PHOTO_INTERVAL_RST;
		cfg.photo_count       = rpps_pkg::PHOTO_COUNT_RST;
		cfg.press_lockout_ms  = rpps_pkg::PRESS_LOCKOUT_RST;
		cfg.slow_blink_ms     = rpps_pkg::SLOW_BLINK_RST;
		cfg.fast_blink_ms     = rpps_pkg::FAST_BLINK_RST;
		seq_ph    = rpps_pkg::PH_IDLE;
		ph_ticks  = '0;
		press_age = '0;
		blink_age = '0;
		shots     = '0;
		btn_prev  = 1'b1;
		led       = 1'b0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_startup();
		test_trigger_rules();
		test_zero_settings();
		test_random_sequences();
		// no idling from here on
		gaps_on = 1'b0;
		test_capture_limit();
		test_large_limits();

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ relay_pulse_photo_sequencer.f @@
rtl/rpps_pkg.sv
rtl/rpps_cfg.sv
rtl/rpps_core.sv
rtl/relay_pulse_photo_sequencer.sv
rtl/rpps_checker.sv
sim/relay_pulse_photo_sequencer_tb.sv
